// ===== rtl/core/sfst_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfst_pkg
// Shared constants and types of the Sobel focus sweep tracker.
// ---------------------------------------------------------------------------
package sfst_pkg;

  localparam int MAX_WIDTH    = 64;
  localparam int HEIGHT_LIMIT = 64;
  localparam int NUM_STEPS    = 16;
  localparam int BORDER       = 1;
  localparam int MIN_GEOM     = 3;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(HEIGHT_LIMIT);
  localparam int PIX_W      = 8;
  localparam int STEP_W     = 4;
  localparam int GEOM_W     = 7;
  localparam int SUM_W      = 31;
  localparam int BEST_W     = 32;
  localparam int IDX_W      = 5;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 20;
  localparam int TERM_W     = SQ_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Per-pixel control that travels with an item down the pipe.
  typedef struct packed {
    logic              interior;
    logic              last;
    logic [STEP_W-1:0] step;
  } pix_ctl_t;

endpackage

// ===== rtl/core/sfst_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfst_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sfst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/sfst_window.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfst_window
// 3x3 window shift and Sobel energy Gx^2 + Gy^2 of the shifted window.
// ---------------------------------------------------------------------------
module sfst_window (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift,
  input  logic [sfst_pkg::PIX_W-1:0]   top,
  input  logic [sfst_pkg::PIX_W-1:0]   mid,
  input  logic [sfst_pkg::PIX_W-1:0]   bot,
  output logic [sfst_pkg::TERM_W-1:0]  term
);

  // Two stored columns; the incoming one completes the window.
  logic [sfst_pkg::PIX_W-1:0] lcol [3];
  logic [sfst_pkg::PIX_W-1:0] rcol [3];

  logic signed [sfst_pkg::GRAD_W-1:0]   gx_pos, gx_neg, gy_pos, gy_neg, gx, gy;
  logic signed [2*sfst_pkg::GRAD_W-1:0] gx_sq, gy_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        lcol[i] <= '0;
        rcol[i] <= '0;
      end
    end else if (shift) begin
      for (int i = 0; i < 3; i++) begin
        lcol[i] <= rcol[i];
      end
      rcol[0] <= top;
      rcol[1] <= mid;
      rcol[2] <= bot;
    end
  end

  always_comb begin
    gx_pos = sfst_pkg::GRAD_W'(top) + (sfst_pkg::GRAD_W'(mid) << 1) + sfst_pkg::GRAD_W'(bot);
    gx_neg = sfst_pkg::GRAD_W'(lcol[0]) + (sfst_pkg::GRAD_W'(lcol[1]) << 1)
           + sfst_pkg::GRAD_W'(lcol[2]);
    gy_pos = sfst_pkg::GRAD_W'(lcol[0]) + (sfst_pkg::GRAD_W'(rcol[0]) << 1)
           + sfst_pkg::GRAD_W'(top);
    gy_neg = sfst_pkg::GRAD_W'(lcol[2]) + (sfst_pkg::GRAD_W'(rcol[2]) << 1)
           + sfst_pkg::GRAD_W'(bot);
    gx     = gx_pos - gx_neg;
    gy     = gy_pos - gy_neg;
    gx_sq  = gx * gx;
    gy_sq  = gy * gy;
    term   = {1'b0, gx_sq[sfst_pkg::SQ_W-1:0]} + {1'b0, gy_sq[sfst_pkg::SQ_W-1:0]};
  end

endmodule

// ===== rtl/core/sfst_tracker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfst_tracker
// Saturating energy sum, best contrast/step update and result register.
// ---------------------------------------------------------------------------
module sfst_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [sfst_pkg::SUM_W-1:0]    threshold,
  input  logic                          take,
  input  sfst_pkg::pix_ctl_t            ctl,
  input  logic [sfst_pkg::TERM_W-1:0]   term,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [sfst_pkg::SUM_W-1:0]    region_contrast,
  output logic signed [sfst_pkg::BEST_W-1:0] best_contrast,
  output logic signed [sfst_pkg::IDX_W-1:0]  best_step,
  output logic                          improved
);

  logic [sfst_pkg::SUM_W-1:0]         energy_sum;
  logic signed [sfst_pkg::BEST_W-1:0] best_energy, best_energy_next;
  logic signed [sfst_pkg::IDX_W-1:0]  best_index, best_index_next;
  logic                               improved_next;

  logic [sfst_pkg::SUM_W:0]           sum_full;
  logic [sfst_pkg::SUM_W-1:0]         total;
  logic                               above_best, above_thr, stale;
  logic [sfst_pkg::SUM_W+3:0]         total_x5, best_x3;

  always_comb begin
    sum_full = {1'b0, energy_sum};
    if (ctl.interior) begin
      sum_full = {1'b0, energy_sum} + (sfst_pkg::SUM_W+1)'(term);
    end
    // saturate at 2^31-1
    total = sum_full[sfst_pkg::SUM_W] ? '1 : sum_full[sfst_pkg::SUM_W-1:0];

    above_best = $signed({2'b00, total}) > $signed({best_energy[sfst_pkg::BEST_W-1], best_energy});
    above_thr  = total > threshold;
    // 0.6 rule: 5*total < 3*best
    total_x5   = ((sfst_pkg::SUM_W+4)'(total) << 2) + (sfst_pkg::SUM_W+4)'(total);
    best_x3    = ((sfst_pkg::SUM_W+4)'(best_energy[sfst_pkg::SUM_W-1:0]) << 1)
               + (sfst_pkg::SUM_W+4)'(best_energy[sfst_pkg::SUM_W-1:0]);
    stale      = (ctl.step == '0) && (best_index == '0) && (total_x5 < best_x3);

    best_energy_next = best_energy;
    best_index_next  = best_index;
    improved_next    = 1'b0;
    priority if (above_best && above_thr) begin
      best_energy_next = sfst_pkg::BEST_W'(total);
      best_index_next  = sfst_pkg::IDX_W'(ctl.step);
      improved_next    = 1'b1;
    end else if (stale) begin
      if (above_thr) begin
        best_energy_next = sfst_pkg::BEST_W'(total);
        best_index_next  = '0;
        improved_next    = 1'b1;
      end else begin
        best_energy_next = '1;
        best_index_next  = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_sum  <= '0;
      best_energy <= '1;
      best_index  <= '1;
      out_valid   <= 1'b0;
    end else begin
      if (restart) begin
        energy_sum <= '0;
      end else if (take) begin
        energy_sum <= ctl.last ? '0 : total;
      end
      if (take && ctl.last) begin
        best_energy <= best_energy_next;
        best_index  <= best_index_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && ctl.last) begin
      region_contrast <= total;
      best_contrast   <= best_energy_next;
      best_step       <= best_index_next;
      improved        <= improved_next;
    end
  end

endmodule

// ===== rtl/core/sobel_focus_sweep_tracker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sobel_focus_sweep_tracker
// Tenengrad (Sobel energy) focus measure of one region, with best-step tracking.
// ---------------------------------------------------------------------------
// Pixels of one region arrive in raster order, one transfer per clock unless
// stalled. Two row RAMs (one read and one write per cycle each) hold the two
// rows above the current one; a 3x3 window forms Gx and Gy on interior pixels,
// and Gx^2+Gy^2 is summed with saturation at 2^31-1. On the region's last pixel
// one result leaves: the region total, the best contrast and step so far
// (-1 = none) and an improved flag. Sustained rate is one pixel per clock while
// the result channel is not stalled, set by the single RAM read port per row;
// a result passes the input register, energy register and result register in
// turn. The row RAMs need no clearing pass: a valid bit per column, cleared at
// reset, makes an unwritten entry read as zero, so pixels are taken right after
// reset. Writing region_width or region_height restarts the region counts and
// sum; configuration is taken at any time (cfg_ready is tied high) but is meant
// to be written only while the block is idle.
// ---------------------------------------------------------------------------
module sobel_focus_sweep_tracker (
  input  logic                                clk,
  input  logic                                rst,
  // pixel channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sfst_pkg::PIX_W-1:0]          pixel,
  input  logic [sfst_pkg::STEP_W-1:0]         focus_step,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sfst_pkg::SUM_W-1:0]          region_contrast,
  output logic signed [sfst_pkg::BEST_W-1:0]  best_contrast,
  output logic signed [sfst_pkg::IDX_W-1:0]   best_step,
  output logic                                improved,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfst_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration: geometry is kept as clamped last column / last row.
  logic [sfst_pkg::COL_W-1:0] col_last;
  logic [sfst_pkg::ROW_W-1:0] row_last;
  logic [sfst_pkg::SUM_W-1:0] threshold;
  logic                       cfg_write, restart;
  logic [31:0]                geom_val;
  logic [sfst_pkg::COL_W-1:0] col_last_next;
  logic [sfst_pkg::ROW_W-1:0] row_last_next;

  // Raster position of the next pixel.
  logic [sfst_pkg::COL_W-1:0] col_count;
  logic [sfst_pkg::ROW_W-1:0] row_count;

  // Stage 1: accepted pixel waiting for its row RAM data.
  logic                        in_accept;
  logic                        s1_valid, s1_advance, s1_fire;
  logic [sfst_pkg::PIX_W-1:0]  s1_pixel;
  logic [sfst_pkg::COL_W-1:0]  s1_col;
  logic                        s1_hit_mid, s1_hit_top;
  sfst_pkg::pix_ctl_t          s1_ctl, in_ctl;
  logic [sfst_pkg::STEP_W-1:0] step_clamped;

  // Row RAMs and their per-column valid bits.
  logic [sfst_pkg::PIX_W-1:0]     mid_rd, top_rd, mid_pix, top_pix;
  logic [sfst_pkg::MAX_WIDTH-1:0] mid_vld, top_vld;

  // Stage 2: energy term of the pixel.
  logic [sfst_pkg::TERM_W-1:0] term, s2_term;
  logic                        s2_valid, s2_advance;
  sfst_pkg::pix_ctl_t          s2_ctl;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign geom_val  = 32'(cfg_data[sfst_pkg::GEOM_W-1:0]);

  always_comb begin
    // clamp width to [3, MAX_WIDTH] and height to [3, HEIGHT_LIMIT]
    priority if (geom_val < 32'(sfst_pkg::MIN_GEOM)) begin
      col_last_next = sfst_pkg::COL_W'(sfst_pkg::MIN_GEOM - 1);
    end else if (geom_val > 32'(sfst_pkg::MAX_WIDTH)) begin
      col_last_next = sfst_pkg::COL_W'(sfst_pkg::MAX_WIDTH - 1);
    end else begin
      col_last_next = sfst_pkg::COL_W'(geom_val - 32'd1);
    end
    priority if (geom_val < 32'(sfst_pkg::MIN_GEOM)) begin
      row_last_next = sfst_pkg::ROW_W'(sfst_pkg::MIN_GEOM - 1);
    end else if (geom_val > 32'(sfst_pkg::HEIGHT_LIMIT)) begin
      row_last_next = sfst_pkg::ROW_W'(sfst_pkg::HEIGHT_LIMIT - 1);
    end else begin
      row_last_next = sfst_pkg::ROW_W'(geom_val - 32'd1);
    end
  end

  always_comb begin
    restart = 1'b0;
    if (cfg_write) begin
      unique case (cfg_index)
        sfst_pkg::REG_WIDTH:  restart = 1'b1;
        sfst_pkg::REG_HEIGHT: restart = 1'b1;
        default:              restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_last  <= sfst_pkg::COL_W'(sfst_pkg::MAX_WIDTH - 1);
      row_last  <= sfst_pkg::ROW_W'(sfst_pkg::HEIGHT_LIMIT - 1);
      threshold <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sfst_pkg::REG_WIDTH:     col_last  <= col_last_next;
        sfst_pkg::REG_HEIGHT:    row_last  <= row_last_next;
        sfst_pkg::REG_THRESHOLD: threshold <= cfg_data[sfst_pkg::SUM_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // Hold stage 2 only when it carries a result and the result register is full and stalled.
  assign s2_advance = !(s2_valid && s2_ctl.last && out_valid && out_stall);
  assign s1_advance = !s2_valid || s2_advance;
  assign s1_fire    = s1_valid && s1_advance;
  assign in_stall   = s1_valid && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  always_comb begin
    step_clamped = focus_step;
    if (32'(focus_step) > 32'(sfst_pkg::NUM_STEPS - 1)) begin
      step_clamped = sfst_pkg::STEP_W'(sfst_pkg::NUM_STEPS - 1);
    end
    in_ctl.interior = (32'(col_count) >= 32'(2 * sfst_pkg::BORDER))
                   && (32'(row_count) >= 32'(2 * sfst_pkg::BORDER));
    in_ctl.last     = (col_count == col_last) && (row_count == row_last);
    in_ctl.step     = step_clamped;
  end

  // Raster counters advance on every pixel transfer.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      if (col_count == col_last) begin
        col_count <= '0;
        row_count <= (row_count == row_last) ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pixel   <= pixel;
      s1_col     <= col_count;
      s1_ctl     <= in_ctl;
      s1_hit_mid <= mid_vld[col_count];
      s1_hit_top <= top_vld[col_count];
    end
  end

  // ---------------- row storage ----------------
  // Never-written columns read as zero.
  assign mid_pix = s1_hit_mid ? mid_rd : '0;
  assign top_pix = s1_hit_top ? top_rd : '0;

  sfst_ram #(
    .WIDTH (sfst_pkg::PIX_W),
    .DEPTH (sfst_pkg::MAX_WIDTH)
  ) u_mid_row (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col),
    .wdata (s1_pixel),
    .re    (in_accept),
    .raddr (col_count),
    .rdata (mid_rd)
  );

  sfst_ram #(
    .WIDTH (sfst_pkg::PIX_W),
    .DEPTH (sfst_pkg::MAX_WIDTH)
  ) u_top_row (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col),
    .wdata (mid_pix),
    .re    (in_accept),
    .raddr (col_count),
    .rdata (top_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_vld <= '0;
      top_vld <= '0;
    end else if (s1_fire) begin
      mid_vld[s1_col] <= 1'b1;
      top_vld[s1_col] <= 1'b1;
    end
  end

  // ---------------- window and energy ----------------
  sfst_window u_window (
    .clk   (clk),
    .rst   (rst),
    .shift (s1_fire),
    .top   (top_pix),
    .mid   (mid_pix),
    .bot   (s1_pixel),
    .term  (term)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_term <= term;
      s2_ctl  <= s1_ctl;
    end
  end

  // ---------------- sum, best tracking, result ----------------
  sfst_tracker u_tracker (
    .clk             (clk),
    .rst             (rst),
    .restart         (restart),
    .threshold       (threshold),
    .take            (s2_valid && s2_advance),
    .ctl             (s2_ctl),
    .term            (s2_term),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .region_contrast (region_contrast),
    .best_contrast   (best_contrast),
    .best_step       (best_step),
    .improved        (improved)
  );

  // ---------------- assertions ----------------
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s2_valid)
    else $error("input stalled without a blocked pipeline");

  a_counts_in_region: assert property (@(posedge clk) disable iff (rst)
    (col_count <= col_last) && (row_count <= row_last))
    else $error("raster counters outside the region");

  a_improved_is_best: assert property (@(posedge clk) disable iff (rst)
    out_valid && improved |->
      (best_contrast == $signed({1'b0, region_contrast})) && (best_step != '1))
    else $error("improved result does not match the stored best");

  a_none_is_paired: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((best_step == '1) == (best_contrast == '1)))
    else $error("best step and best contrast disagree on none");

endmodule
